/* hw/rtl/lhr_pkg.sv */
package lhr_pkg;

    // Hue sectors, each one sixth of a turn.
    localparam logic [2:0] SEC_RED_YELLOW     = 3'd0;
    localparam logic [2:0] SEC_YELLOW_GREEN   = 3'd1;
    localparam logic [2:0] SEC_GREEN_CYAN     = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLUE      = 3'd3;
    localparam logic [2:0] SEC_BLUE_MAGENTA   = 3'd4;
    localparam logic [2:0] SEC_MAGENTA_RED    = 3'd5;

    // Per-stage control that travels down the pipeline with each request.
    typedef struct packed {
        logic       valid;
        logic [2:0] sector;
        logic [7:0] val;
        logic [7:0] alpha;
    } t_stage;

    // Exact floor(q / 255) for q up to 255 * 255, done with a reciprocal add.
    function automatic logic [7:0] div255(input logic [15:0] q);
        logic [16:0] t;
        t = {1'b0, q} + {9'd0, q[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

/* hw/rtl/looping_hue_to_rgba.sv */
// Looping hue to RGBA converter.
// A request is taken at each rising edge where start is high and busy is low.
// It carries a hue phase (a fraction of a full turn, wrapping), a saturation,
// a brightness and an alpha byte; 255 means full scale for the bytes.
// Each request produces one packed RGBA word on o_packed_color, marked by a
// one-cycle o_valid pulse, red in the top byte and alpha in the low byte.
// Throughput is one request per cycle: the five register stages
// (sector split, weight, chroma multiply, divide by 255, channel select)
// each hold an independent request, and busy stays low.
// The receiver cannot stall, so no result is ever held back; every request
// comes out in order exactly once.
// A synchronous reset clears every stage valid bit, dropping requests that
// were in flight; no result appears until a new request is accepted.
module looping_hue_to_rgba
    import lhr_pkg::*;
#(
    parameter int HUE_PHASE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_hue_phase,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    input  logic [7:0]  i_alpha,
    output logic        o_valid,
    output logic [31:0] o_packed_color
);

    t_stage                  front_stage;
    logic [HUE_PHASE_BITS:0] front_k;
    logic [15:0]             front_m;
    logic [15:0]             front_vs;
    t_stage                  chan_stage;
    logic [7:0]              chan_x;
    logic [7:0]              chan_m;
    logic [7:0]              n_red;
    logic [7:0]              n_green;
    logic [7:0]              n_blue;
    logic                    r_valid;
    logic [31:0]             r_color;

    // The pipeline never stalls.
    assign busy = 1'b0;

    lhr_hue_front #(
        .HUE_PHASE_BITS(HUE_PHASE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start && !busy),
        .i_hue_phase (i_hue_phase),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .i_alpha     (i_alpha),
        .o_stage     (front_stage),
        .o_k         (front_k),
        .o_m         (front_m),
        .o_vs        (front_vs)
    );

    lhr_chan_calc #(
        .HUE_PHASE_BITS(HUE_PHASE_BITS)
    ) u_chan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stage(front_stage),
        .i_k    (front_k),
        .i_m    (front_m),
        .i_vs   (front_vs),
        .o_stage(chan_stage),
        .o_x    (chan_x),
        .o_m    (chan_m)
    );

    // Route the max, ramp and min levels to the channels by sector.
    // The max level is the brightness itself.
    always_comb begin
        case (chan_stage.sector)
            SEC_RED_YELLOW: begin
                n_red = chan_stage.val; n_green = chan_x;          n_blue = chan_m;
            end
            SEC_YELLOW_GREEN: begin
                n_red = chan_x;         n_green = chan_stage.val;  n_blue = chan_m;
            end
            SEC_GREEN_CYAN: begin
                n_red = chan_m;         n_green = chan_stage.val;  n_blue = chan_x;
            end
            SEC_CYAN_BLUE: begin
                n_red = chan_m;         n_green = chan_x;          n_blue = chan_stage.val;
            end
            SEC_BLUE_MAGENTA: begin
                n_red = chan_x;         n_green = chan_m;          n_blue = chan_stage.val;
            end
            default: begin
                n_red = chan_stage.val; n_green = chan_m;          n_blue = chan_x;
            end
        endcase
    end

    // Stage 5: output register and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chan_stage.valid;
        end
        r_color <= {n_red, n_green, n_blue, chan_stage.alpha};
    end

    assign o_valid        = r_valid;
    assign o_packed_color = r_color;

endmodule

/* hw/rtl/lhr_hue_front.sv */
module lhr_hue_front
    import lhr_pkg::*;
#(
    parameter int HUE_PHASE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [15:0]             i_hue_phase,
    input  logic [7:0]              i_saturation,
    input  logic [7:0]              i_brightness,
    input  logic [7:0]              i_alpha,
    output t_stage                  o_stage,
    output logic [HUE_PHASE_BITS:0] o_k,
    output logic [15:0]             o_m,
    output logic [15:0]             o_vs
);

    localparam int P  = HUE_PHASE_BITS;
    localparam int PW = (P < 16) ? P : 16;

    logic [P-1:0] phase;
    logic [P+2:0] six;
    t_stage       n_s1;
    t_stage       r_s1;
    logic [P-1:0] r_s1_frac;
    logic [15:0]  r_s1_vs;
    logic [P:0]   n_k;
    logic [15:0]  n_m;
    t_stage       r_s2;
    logic [P:0]   r_s2_k;
    logic [15:0]  r_s2_m;
    logic [15:0]  r_s2_vs;

    // Only the low bits of the phase count; higher bits are whole turns.
    assign phase = P'(i_hue_phase[PW-1:0]);
    assign six   = ({3'd0, phase} << 2) + ({3'd0, phase} << 1);

    always_comb begin
        n_s1.valid  = i_accept;
        n_s1.sector = six[P+2:P];
        n_s1.val    = i_brightness;
        n_s1.alpha  = i_alpha;
    end

    // Stage 1: sector, fraction and the value-saturation product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
        r_s1_frac <= six[P-1:0];
        r_s1_vs   <= {8'd0, i_brightness} * {8'd0, i_saturation};
    end

    // Falling edge of the sector uses one minus the fraction.
    always_comb begin
        if (r_s1.sector[0]) begin
            n_k = {1'b1, {P{1'b0}}} - {1'b0, r_s1_frac};
        end else begin
            n_k = {1'b0, r_s1_frac};
        end
        n_m = {r_s1.val, 8'd0} - {8'd0, r_s1.val} - r_s1_vs;
    end

    // Stage 2: interpolation weight and the 255-scaled minimum component.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= r_s1;
        end
        r_s2_k  <= n_k;
        r_s2_m  <= n_m;
        r_s2_vs <= r_s1_vs;
    end

    assign o_stage = r_s2;
    assign o_k     = r_s2_k;
    assign o_m     = r_s2_m;
    assign o_vs    = r_s2_vs;

endmodule

/* hw/rtl/lhr_chan_calc.sv */
module lhr_chan_calc
    import lhr_pkg::*;
#(
    parameter int HUE_PHASE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stage                  i_stage,
    input  logic [HUE_PHASE_BITS:0] i_k,
    input  logic [15:0]             i_m,
    input  logic [15:0]             i_vs,
    output t_stage                  o_stage,
    output logic [7:0]              o_x,
    output logic [7:0]              o_m
);

    localparam int P = HUE_PHASE_BITS;

    t_stage        r_s3;
    logic [P+16:0] r_s3_prod;
    logic [15:0]   r_s3_m;
    logic [15:0]   n_qx;
    t_stage        r_s4;
    logic [7:0]    r_s4_x;
    logic [7:0]    r_s4_m;

    // Stage 3: scale the chroma by the interpolation weight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3 <= i_stage;
        end
        r_s3_prod <= {{(P+1){1'b0}}, i_vs} * {16'd0, i_k};
        r_s3_m    <= i_m;
    end

    // The product never exceeds the chroma, so the sum stays within 16 bits.
    assign n_qx = r_s3_m + r_s3_prod[P+15:P];

    // Stage 4: bring both levels back to the 0..255 scale.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else begin
            r_s4 <= r_s3;
        end
        r_s4_x <= div255(n_qx);
        r_s4_m <= div255(r_s3_m);
    end

    assign o_stage = r_s4;
    assign o_x     = r_s4_x;
    assign o_m     = r_s4_m;

endmodule

/* hw/rtl/lhr_checker.sv */
module lhr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  i_saturation,
    input logic [7:0]  i_brightness,
    input logic [7:0]  i_alpha,
    input logic        o_valid,
    input logic [31:0] o_packed_color
);

    // Every accepted request yields a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted request produced no result");

    // A result only appears for an earlier accepted request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result without a matching request");

    // Alpha passes straight through.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_packed_color[7:0] == $past(i_alpha, 5)))
        else $error("alpha byte corrupted");

    // No channel exceeds the brightness.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_packed_color[31:24] <= $past(i_brightness, 5)
                  && o_packed_color[23:16] <= $past(i_brightness, 5)
                  && o_packed_color[15:8]  <= $past(i_brightness, 5)))
        else $error("channel above brightness");

    // Zero saturation gives grey at the brightness level.
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_saturation, 5) == 8'd0) |->
            (o_packed_color[31:24] == $past(i_brightness, 5)
          && o_packed_color[23:16] == $past(i_brightness, 5)
          && o_packed_color[15:8]  == $past(i_brightness, 5)))
        else $error("unsaturated color is not grey");

endmodule

bind looping_hue_to_rgba lhr_checker u_lhr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_saturation  (i_saturation),
    .i_brightness  (i_brightness),
    .i_alpha       (i_alpha),
    .o_valid       (o_valid),
    .o_packed_color(o_packed_color)
);
